### sv/assert_macros.svh
// Assertion macros shared by the alarm timer table RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same clock edge.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must never be seen at a clock edge.
`define CHK_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

### sv/mstt_pkg.sv
// Package for the multi-slot alarm timer table: field widths, codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mstt_pkg;

   // Field widths of the item channels.
   localparam int OP_W     = 2;
   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 32;
   localparam int ID_W     = 4;
   localparam int STAT_W   = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_ID = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic decode;
      logic ff_step;
      logic end_step;
      logic clamp;
      logic begin_step;
      logic scan_next;
      logic scan_read;
      logic fire;
      logic rearm;
      logic free_scan;
      logic emit_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ff_full;
      logic            sid_bad;
      logic            ff_more;
      logic            end_more;
      logic            clamp_match;
      logic            begin_more;
      logic            scan_done;
      logic            scan_act;
      logic            due_hit;
      logic            period_zero;
      logic            pending;
      logic            out_free;
   } stat_type;

endpackage

### sv/mstt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the slot period and due time stores.
`timescale 1ns / 1ps

module mstt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mstt_ctrl.sv
// Controller state machine of the alarm timer table: sequences decode, mark
// walks, the slot scan and result hand-off. Depends on mstt_pkg.
`timescale 1ns / 1ps

module mstt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mstt_pkg::stat_type st,
   output mstt_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DECODE     = 4'd1;
   localparam logic [3:0] S_WALK_FF    = 4'd2;
   localparam logic [3:0] S_WALK_END   = 4'd3;
   localparam logic [3:0] S_CLAMP      = 4'd4;
   localparam logic [3:0] S_WALK_BEGIN = 4'd5;
   localparam logic [3:0] S_SCAN_RD    = 4'd6;
   localparam logic [3:0] S_SCAN_EVAL  = 4'd7;
   localparam logic [3:0] S_RESP       = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       is_check;

   assign is_check  = (st.op == mstt_pkg::OP_CHECK);
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (st.op == mstt_pkg::OP_CREATE && !st.ff_full) begin
               state_in = S_WALK_FF;
            end else if (st.op == mstt_pkg::OP_CANCEL && !st.sid_bad) begin
               state_in = S_WALK_END;
            end else if (is_check) begin
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK_FF: begin
            if (st.ff_more) begin
               cmd.ff_step = 1'b1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK_END: begin
            if (st.end_more) begin
               cmd.end_step = 1'b1;
            end else begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            if (st.clamp_match) begin
               state_in = S_WALK_BEGIN;
            end else if (is_check) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK_BEGIN: begin
            if (st.begin_more) begin
               cmd.begin_step = 1'b1;
            end else if (is_check) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN_RD: begin
            if (st.scan_done) begin
               state_in = S_RESP;
            end else if (!st.scan_act) begin
               cmd.scan_next = 1'b1;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = S_SCAN_EVAL;
            end
         end
         S_SCAN_EVAL: begin
            if (!st.due_hit) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else if (!st.pending || st.out_free) begin
               cmd.fire = 1'b1;
               if (st.period_zero) begin
                  cmd.free_scan = 1'b1;
                  state_in      = S_WALK_END;
               end else begin
                  cmd.rearm     = 1'b1;
                  cmd.scan_next = 1'b1;
                  state_in      = S_SCAN_RD;
               end
            end
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/mstt_dp.sv
// Datapath of the alarm timer table: active bits, marks, slot stores, scan
// index and result registers. Depends on mstt_pkg, mstt_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mstt_dp #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mstt_pkg::cmd_type                 cmd,
   output mstt_pkg::stat_type                st,
   input  logic [mstt_pkg::OP_W-1:0]         req_operation,
   input  logic [mstt_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [mstt_pkg::PERIOD_W-1:0]     req_period_ms,
   input  logic                              req_repeating,
   input  logic [mstt_pkg::ID_W-1:0]         req_slot_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mstt_pkg::ID_W-1:0]         rsp_timer_id,
   output logic                              rsp_fired,
   output logic [mstt_pkg::STAT_W-1:0]       rsp_status,
   output logic                              rsp_last
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int MW = $clog2(NUM_SLOTS + 1);
   localparam int TW = mstt_pkg::TIME_W;
   localparam int PW = mstt_pkg::PERIOD_W;
   localparam int DW = mstt_pkg::ID_W;
   localparam logic [MW-1:0] N_M = MW'(NUM_SLOTS);

   // Active bit of a slot; positions past the table read as free.
   function automatic logic act_at(input logic [NUM_SLOTS-1:0] vec,
                                   input logic [MW-1:0] idx);
      logic r;
      r = 1'b0;
      if (idx < N_M) begin
         r = vec[idx[IW-1:0]];
      end
      return r;
   endfunction

   // Low bits of a slot number as a timer id.
   function automatic logic [DW-1:0] to_id(input logic [MW-1:0] idx);
      logic [MW+DW-1:0] w;
      w = {{DW{1'b0}}, idx};
      return w[DW-1:0];
   endfunction

   // Captured item.
   logic [mstt_pkg::OP_W-1:0] op_ff;
   logic [TW-1:0]             now_ff;
   logic [PW-1:0]             period_ff;
   logic                      rep_ff;
   logic [DW-1:0]             sid_ff;

   // Slot state and marks.
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [MW-1:0]        ff_ff, ff_in;
   logic [MW-1:0]        begin_ff, begin_in;
   logic [MW-1:0]        end_ff, end_in;
   logic [MW-1:0]        stop_ff, stop_in;
   logic [MW-1:0]        scan_ff, scan_in;
   logic [MW-1:0]        free_idx_ff, free_idx_in;

   // Held result and output register.
   logic [DW-1:0]                 res_id_ff, res_id_in;
   logic                          res_fired_ff, res_fired_in;
   logic [mstt_pkg::STAT_W-1:0]   res_status_ff, res_status_in;
   logic                          pending_ff, pending_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                 rsp_id_ff;
   logic                          rsp_fired_ff;
   logic [mstt_pkg::STAT_W-1:0]   rsp_status_ff;
   logic                          rsp_last_ff;

   // Working signals.
   logic [MW+DW-1:0] sid_w, end_w;
   logic [MW-1:0]    sid_m, begin_min, ff_plus, free_src;
   logic             ff_full, sid_bad, create_wr, free_req, load_rsp, out_free;
   logic [TW-1:0]    due_rd, add_a, due_sum;
   logic [PW-1:0]    period_rd, add_b, period_wr;
   logic [TW:0]      sum_w;
   logic [IW-1:0]    wr_addr;

   // Decode-side compares and the saturating due time adder.
   always_comb begin
      ff_full   = (ff_ff >= N_M);
      sid_w     = {{MW{1'b0}}, sid_ff};
      end_w     = {{DW{1'b0}}, end_ff};
      sid_bad   = (sid_w >= end_w);
      sid_m     = sid_w[MW-1:0];
      begin_min = (begin_ff < end_ff) ? begin_ff : end_ff;
      ff_plus   = ff_ff + MW'(1);
      create_wr = cmd.decode && (op_ff == mstt_pkg::OP_CREATE) && !ff_full;
      free_req  = (cmd.decode && (op_ff == mstt_pkg::OP_CANCEL) && !sid_bad)
                  || cmd.free_scan;
      free_src  = cmd.free_scan ? scan_ff : sid_m;
      add_a     = cmd.rearm ? due_rd : now_ff;
      add_b     = cmd.rearm ? period_rd : period_ff;
      sum_w     = {1'b0, add_a} + {{(TW + 1 - PW){1'b0}}, add_b};
      due_sum   = sum_w[TW] ? {TW{1'b1}} : sum_w[TW-1:0];
      period_wr = rep_ff ? period_ff : '0;
      wr_addr   = cmd.rearm ? scan_ff[IW-1:0] : ff_ff[IW-1:0];
      out_free  = !rsp_valid_ff || !rsp_stall;
      load_rsp  = (cmd.fire && pending_ff) || cmd.emit_last;
   end

   // Slot stores: due time and re-arm period.
   mstt_ram #(.WIDTH(TW), .DEPTH(NUM_SLOTS)) u_due_ram (
      .clock   (clock),
      .wr_en   (create_wr || cmd.rearm),
      .wr_addr (wr_addr),
      .wr_data (due_sum),
      .rd_en   (cmd.scan_read),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_data (due_rd)
   );

   mstt_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (create_wr),
      .wr_addr (ff_ff[IW-1:0]),
      .wr_data (period_wr),
      .rd_en   (cmd.scan_read),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_data (period_rd)
   );

   // Next values of the marks, active bits and held result.
   always_comb begin
      active_in     = active_ff;
      ff_in         = ff_ff;
      begin_in      = begin_ff;
      end_in        = end_ff;
      stop_in       = stop_ff;
      scan_in       = scan_ff;
      free_idx_in   = free_idx_ff;
      res_id_in     = res_id_ff;
      res_fired_in  = res_fired_ff;
      res_status_in = res_status_ff;
      pending_in    = pending_ff;

      if (cmd.decode) begin
         unique case (op_ff)
            mstt_pkg::OP_CREATE: begin
               if (ff_full) begin
                  res_id_in     = '0;
                  res_status_in = mstt_pkg::ST_FULL;
               end else begin
                  res_id_in                  = to_id(ff_ff);
                  res_status_in              = mstt_pkg::ST_OK;
                  active_in[ff_ff[IW-1:0]]   = 1'b1;
                  begin_in = (ff_ff < begin_ff) ? ff_ff : begin_ff;
                  ff_in    = ff_plus;
                  end_in   = (end_ff < ff_plus) ? ff_plus : end_ff;
               end
               res_fired_in = 1'b0;
            end
            mstt_pkg::OP_CANCEL: begin
               res_id_in     = sid_ff;
               res_fired_in  = 1'b0;
               res_status_in = sid_bad ? mstt_pkg::ST_BAD_ID : mstt_pkg::ST_OK;
            end
            mstt_pkg::OP_CHECK: begin
               scan_in       = begin_ff;
               stop_in       = end_ff;
               pending_in    = 1'b0;
               res_id_in     = '0;
               res_fired_in  = 1'b0;
               res_status_in = mstt_pkg::ST_OK;
            end
            default: begin
               res_id_in     = '0;
               res_fired_in  = 1'b0;
               res_status_in = mstt_pkg::ST_OK;
            end
         endcase
      end

      // First step of freeing a slot: clear it, pull first-free down and
      // drop the end mark when the top slot goes.
      if (free_req) begin
         active_in[free_src[IW-1:0]] = 1'b0;
         free_idx_in = free_src;
         if (free_src < ff_ff) begin
            ff_in = free_src;
         end
         if (end_ff != '0 && free_src == end_ff - MW'(1)) begin
            end_in = end_ff - MW'(1);
         end
      end

      // One step of each mark walk.
      if (cmd.ff_step) begin
         ff_in = ff_plus;
      end
      if (cmd.end_step) begin
         end_in = end_ff - MW'(1);
      end
      if (cmd.clamp) begin
         begin_in = begin_min;
      end
      if (cmd.begin_step) begin
         begin_in = begin_ff + MW'(1);
      end
      if (cmd.scan_next) begin
         scan_in = scan_ff + MW'(1);
      end

      // A firing slot becomes the held result; the previous one goes out.
      if (cmd.fire) begin
         res_id_in     = to_id(scan_ff);
         res_fired_in  = 1'b1;
         res_status_in = mstt_pkg::ST_OK;
         pending_in    = 1'b1;
      end
   end

   // Output register valid.
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         ff_ff        <= '0;
         begin_ff     <= '0;
         end_ff       <= '0;
         stop_ff      <= '0;
         scan_ff      <= '0;
         free_idx_ff  <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         ff_ff        <= ff_in;
         begin_ff     <= begin_in;
         end_ff       <= end_in;
         stop_ff      <= stop_in;
         scan_ff      <= scan_in;
         free_idx_ff  <= free_idx_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         now_ff    <= req_now_ms;
         period_ff <= req_period_ms;
         rep_ff    <= req_repeating;
         sid_ff    <= req_slot_id;
      end
      res_id_ff     <= res_id_in;
      res_fired_ff  <= res_fired_in;
      res_status_ff <= res_status_in;
      if (load_rsp) begin
         rsp_id_ff     <= res_id_ff;
         rsp_fired_ff  <= res_fired_ff;
         rsp_status_ff <= res_status_ff;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   // Status towards the controller.
   always_comb begin
      st.op          = op_ff;
      st.ff_full     = ff_full;
      st.sid_bad     = sid_bad;
      st.ff_more     = (ff_ff < end_ff) && act_at(active_ff, ff_ff);
      st.end_more    = (end_ff != '0) && !act_at(active_ff, end_ff - MW'(1));
      st.clamp_match = (free_idx_ff == begin_min);
      st.begin_more  = (begin_ff < end_ff) && !act_at(active_ff, begin_ff);
      st.scan_done   = (scan_ff >= stop_ff);
      st.scan_act    = act_at(active_ff, scan_ff);
      st.due_hit     = (due_rd <= now_ff);
      st.period_zero = (period_rd == '0);
      st.pending     = pending_ff;
      st.out_free    = out_free;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_timer_id = rsp_id_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

   // The end mark stays within the table and first-free never passes it.
   `CHK_NEVER(a_end_bound, clock, reset, end_ff > N_M, "end mark beyond table")
   `CHK_NEVER(a_ff_le_end, clock, reset, ff_ff > end_ff, "first free beyond end mark")
   // A result waiting on a stalled consumer is never overwritten.
   `CHK_NEVER(a_rsp_hold, clock, reset, load_rsp && rsp_valid_ff && rsp_stall, "result overwritten")
   // Only an active slot is re-armed.
   `CHK_IMPLY(a_rearm_active, clock, reset, cmd.rearm, st.scan_act, "re-arm of free slot")

endmodule

### sv/multi_slot_alarm_timer_table.sv
// Top level of the multi-slot alarm timer table: controller plus datapath.
// Depends on mstt_pkg, mstt_ctrl, mstt_dp and mstt_ram.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   operation, now_ms, period_ms, repeating, slot_id
//   rsp_      out        rsp_valid/rsp_stall   timer_id, fired, status, last
//
// Create walks the first-free mark and cancel walks the end and begin marks, one slot per
// cycle. Check scans the slots between the begin and end marks, reading each active slot
// through the registered read port of the slot stores, and walks the marks whenever a
// one-shot slot frees itself.
// Reset is synchronous and clears the active bits and marks; there is no clearing pass.
// A new item is taken once the previous one's last result sits in the output register.
// A stalled consumer holds the scan when a second fired item is ready to go out, and
// holds the final result while the output register is still full.
`timescale 1ns / 1ps

module multi_slot_alarm_timer_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mstt_pkg::OP_W-1:0]     req_operation,
   input  logic [mstt_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [mstt_pkg::PERIOD_W-1:0] req_period_ms,
   input  logic                          req_repeating,
   input  logic [mstt_pkg::ID_W-1:0]     req_slot_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mstt_pkg::ID_W-1:0]     rsp_timer_id,
   output logic                          rsp_fired,
   output logic [mstt_pkg::STAT_W-1:0]   rsp_status,
   output logic                          rsp_last
);

   mstt_pkg::cmd_type  cmd;
   mstt_pkg::stat_type st;

   // Sequencer.
   mstt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Slot state, marks and result registers.
   mstt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_operation (req_operation),
      .req_now_ms    (req_now_ms),
      .req_period_ms (req_period_ms),
      .req_repeating (req_repeating),
      .req_slot_id   (req_slot_id),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_timer_id  (rsp_timer_id),
      .rsp_fired     (rsp_fired),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

### tb/multi_slot_alarm_timer_table_tb.sv
// Self-checking testbench for the multi-slot alarm timer table.
// Depends on mstt_pkg and multi_slot_alarm_timer_table; a directed table, then random items.
`timescale 1ns / 1ps

module multi_slot_alarm_timer_table_tb;

   localparam int N_SLOTS = 16;
   localparam int OPW = mstt_pkg::OP_W;
   localparam int TMW = mstt_pkg::TIME_W;
   localparam int PRW = mstt_pkg::PERIOD_W;
   localparam int IDW = mstt_pkg::ID_W;
   localparam int STW = mstt_pkg::STAT_W;
   localparam logic [OPW-1:0] OP_SPARE = 2'd3;
   localparam logic [TMW-1:0] TIME_MAX = '1;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 2 * N_SLOTS + 8;
   localparam int ITEMS_PER_PHASE = 89;

   typedef struct packed {
      logic [OPW-1:0] op;
      logic [TMW-1:0] now;
      logic [PRW-1:0] period;
      logic           rep;
      logic [IDW-1:0] sid;
   } alarm_req_type;

   typedef struct packed {
      logic [IDW-1:0] id;
      logic           fired;
      logic [STW-1:0] status;
      logic           last;
   } alarm_rsp_type;

   typedef struct {
      alarm_req_type item;
      int            repeats;
      bit            typed;
      alarm_rsp_type want;
   } plan_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic [OPW-1:0] req_operation = '0;
   logic [TMW-1:0] req_now_ms = '0;
   logic [PRW-1:0] req_period_ms = '0;
   logic           req_repeating = 1'b0;
   logic [IDW-1:0] req_slot_id = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic [IDW-1:0] rsp_timer_id;
   logic           rsp_fired;
   logic [STW-1:0] rsp_status;
   logic           rsp_last;

   // Expected results in order, and the failure count.
   alarm_rsp_type pending_alarms[$];
   alarm_rsp_type head_alarm;
   int            fail_count = 0;

   // Idling rates and the long receiver hold-off request.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Predicted table state.
   logic           armed[N_SLOTS];
   logic [PRW-1:0] interval[N_SLOTS];
   logic [TMW-1:0] deadline[N_SLOTS];
   int             low_free = 0;
   int             lo_mark = 0;
   int             hi_mark = 0;

   plan_row_type directed_plan[$];

   multi_slot_alarm_timer_table #(
      .NUM_SLOTS(N_SLOTS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_now_ms   (req_now_ms),
      .req_period_ms(req_period_ms),
      .req_repeating(req_repeating),
      .req_slot_id  (req_slot_id),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_timer_id (rsp_timer_id),
      .rsp_fired    (rsp_fired),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic alarm_rsp_type make_alarm_rsp(logic [IDW-1:0] id, logic fired,
                                                    logic [STW-1:0] status, logic last);
      alarm_rsp_type r;
      r.id = id;
      r.fired = fired;
      r.status = status;
      r.last = last;
      return r;
   endfunction

   // Due time addition that saturates at the top of the time range.
   function automatic logic [TMW-1:0] due_add(logic [TMW-1:0] a, logic [PRW-1:0] b);
      logic [TMW:0] s;
      s = {1'b0, a} + {{(TMW + 1 - PRW){1'b0}}, b};
      return s[TMW] ? TIME_MAX : s[TMW-1:0];
   endfunction

   // Frees one slot and walks the three marks the way the table does.
   function automatic void release_slot(int idx);
      armed[idx] = 1'b0;
      if (idx < low_free) low_free = idx;
      if (hi_mark > 0 && idx == hi_mark - 1) begin
         hi_mark--;
         while (hi_mark > 0 && !armed[hi_mark - 1]) hi_mark--;
      end
      if (lo_mark > hi_mark) lo_mark = hi_mark;
      if (idx == lo_mark) begin
         while (lo_mark < hi_mark && !armed[lo_mark]) lo_mark++;
      end
   endfunction

   // Applies one item to the predicted table and returns the results it causes.
   function automatic void predict_alarms(input alarm_req_type it,
                                          output alarm_rsp_type res[$]);
      int id;
      int stop;
      res = {};
      case (it.op)
         mstt_pkg::OP_CREATE: begin
            id = low_free;
            if (id >= N_SLOTS) begin
               res.push_back(make_alarm_rsp('0, 1'b0, mstt_pkg::ST_FULL, 1'b1));
            end else begin
               armed[id] = 1'b1;
               interval[id] = it.rep ? it.period : '0;
               deadline[id] = due_add(it.now, it.period);
               if (id < lo_mark) lo_mark = id;
               low_free = id + 1;
               if (hi_mark < low_free) hi_mark = low_free;
               while (low_free < hi_mark && low_free < N_SLOTS && armed[low_free]) low_free++;
               res.push_back(make_alarm_rsp(IDW'(id), 1'b0, mstt_pkg::ST_OK, 1'b1));
            end
         end
         mstt_pkg::OP_CANCEL: begin
            if (int'(it.sid) >= hi_mark) begin
               res.push_back(make_alarm_rsp(it.sid, 1'b0, mstt_pkg::ST_BAD_ID, 1'b1));
            end else begin
               release_slot(int'(it.sid));
               res.push_back(make_alarm_rsp(it.sid, 1'b0, mstt_pkg::ST_OK, 1'b1));
            end
         end
         mstt_pkg::OP_CHECK: begin
            // The scan bounds are taken before any slot frees itself.
            stop = (hi_mark > N_SLOTS) ? N_SLOTS : hi_mark;
            for (int i = lo_mark; i < stop; i++) begin
               if (armed[i] && deadline[i] <= it.now) begin
                  res.push_back(make_alarm_rsp(IDW'(i), 1'b1, mstt_pkg::ST_OK, 1'b0));
                  if (interval[i] != '0) deadline[i] = due_add(deadline[i], interval[i]);
                  else release_slot(i);
               end
            end
            if (res.size() == 0) res.push_back(make_alarm_rsp('0, 1'b0, mstt_pkg::ST_OK, 1'b1));
            else res[res.size() - 1].last = 1'b1;
         end
         default: begin
            res.push_back(make_alarm_rsp('0, 1'b0, mstt_pkg::ST_OK, 1'b1));
         end
      endcase
   endfunction

   // Offers one item, waits for it to be taken, and files its expected results.
   task automatic send_alarm_req(input alarm_req_type it, input bit typed,
                                 input alarm_rsp_type want);
      int gap;
      alarm_rsp_type res[$];
      gap = 0;
      if ($urandom_range(99) < req_idle_pct) gap = $urandom_range(4, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.op;
      req_now_ms <= it.now;
      req_period_ms <= it.period;
      req_repeating <= it.rep;
      req_slot_id <= it.sid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_alarms(it, res);
      if (typed) pending_alarms.push_back(want);
      else foreach (res[i]) pending_alarms.push_back(res[i]);
   endtask

   task automatic plan_row(logic [OPW-1:0] op, logic [TMW-1:0] now,
                           logic [PRW-1:0] period, logic rep, logic [IDW-1:0] sid,
                           int repeats, bit typed, alarm_rsp_type want);
      plan_row_type row;
      row.item.op = op;
      row.item.now = now;
      row.item.period = period;
      row.item.rep = rep;
      row.item.sid = sid;
      row.repeats = repeats;
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endtask

   // Builds one random item, mostly well-formed traffic on a moving clock.
   function automatic alarm_req_type random_alarm_req(logic [TMW-1:0] wall_ms);
      alarm_req_type it;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) it.op = mstt_pkg::OP_CREATE;
      else if (pick < 60) it.op = mstt_pkg::OP_CANCEL;
      else if (pick < 95) it.op = mstt_pkg::OP_CHECK;
      else it.op = OP_SPARE;
      pick = $urandom_range(31);
      if (pick == 0) it.now = TIME_MAX;
      else if (pick < 3) it.now = {16'($urandom()), $urandom()};
      else it.now = wall_ms;
      pick = $urandom_range(31);
      if (pick == 0) it.period = '1;
      else if (pick < 5) it.period = $urandom();
      else it.period = $urandom_range(150);
      it.rep = 1'($urandom_range(1));
      // Cancels mostly aim at slots that the table can still hold.
      if (it.op == mstt_pkg::OP_CANCEL && hi_mark > 0 && $urandom_range(9) < 7)
         it.sid = IDW'($urandom_range(hi_mark - 1));
      else
         it.sid = IDW'($urandom_range(N_SLOTS - 1));
      return it;
   endfunction

   // Receiver stall: random idling, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_alarms.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected result id=%0d fired=%0b status=%0d last=%0b",
                        $realtime, rsp_timer_id, rsp_fired, rsp_status, rsp_last);
         end else begin
            head_alarm = pending_alarms.pop_front();
            if (rsp_timer_id !== head_alarm.id || rsp_fired !== head_alarm.fired ||
                rsp_status !== head_alarm.status || rsp_last !== head_alarm.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: mismatch expected id=%0d fired=%0b status=%0d last=%0b, %s",
                           $realtime, head_alarm.id, head_alarm.fired, head_alarm.status,
                           head_alarm.last,
                           $sformatf("got id=%0d fired=%0b status=%0d last=%0b",
                                     rsp_timer_id, rsp_fired, rsp_status, rsp_last));
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [TMW-1:0] wall_ms;
      alarm_req_type it;
      alarm_rsp_type none;
      none = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
         armed[i] = 1'b0;
         interval[i] = '0;
         deadline[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct <= 19;
      rsp_idle_pct <= 80;

      // Directed table: empty table, operation extremes, fill to full, one big scan.
      plan_row(mstt_pkg::OP_CHECK, TIME_MAX, '1, 1'b1, '1, 1, 1,
               make_alarm_rsp('0, 1'b0, mstt_pkg::ST_OK, 1'b1));
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, '0, 1, 1,
               make_alarm_rsp('0, 1'b0, mstt_pkg::ST_BAD_ID, 1'b1));
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, 4'd15, 1, 1,
               make_alarm_rsp(4'd15, 1'b0, mstt_pkg::ST_BAD_ID, 1'b1));
      plan_row(OP_SPARE, TIME_MAX, '1, 1'b1, '1, 1, 1,
               make_alarm_rsp('0, 1'b0, mstt_pkg::ST_OK, 1'b1));
      plan_row(mstt_pkg::OP_CREATE, '0, '0, 1'b0, '0, 1, 1,
               make_alarm_rsp(4'd0, 1'b0, mstt_pkg::ST_OK, 1'b1));
      // This due time saturates at the top of the time range.
      plan_row(mstt_pkg::OP_CREATE, TIME_MAX, '1, 1'b1, '1, 1, 1,
               make_alarm_rsp(4'd1, 1'b0, mstt_pkg::ST_OK, 1'b1));
      plan_row(mstt_pkg::OP_CREATE, 48'd100, 32'd50, 1'b1, '0, 1, 1,
               make_alarm_rsp(4'd2, 1'b0, mstt_pkg::ST_OK, 1'b1));
      // Repeating with a zero period behaves as one-shot.
      plan_row(mstt_pkg::OP_CREATE, 48'd10, '0, 1'b1, '0, 1, 1,
               make_alarm_rsp(4'd3, 1'b0, mstt_pkg::ST_OK, 1'b1));
      plan_row(mstt_pkg::OP_CHECK, '0, '0, 1'b0, '0, 1, 0, none);
      plan_row(mstt_pkg::OP_CHECK, 48'd149, '0, 1'b0, '0, 1, 0, none);
      plan_row(mstt_pkg::OP_CHECK, 48'd150, '0, 1'b0, '0, 1, 0, none);
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, 4'd2, 1, 0, none);
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, 4'd2, 1, 0, none);
      // Cancelling a slot that is already free still counts as a normal cancel.
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, 4'd0, 1, 0, none);
      plan_row(mstt_pkg::OP_CREATE, 48'd500, 32'd1000, 1'b0, '0, N_SLOTS - 1, 0, none);
      plan_row(mstt_pkg::OP_CREATE, 48'd500, 32'd1000, 1'b0, '0, 1, 1,
               make_alarm_rsp('0, 1'b0, mstt_pkg::ST_FULL, 1'b1));
      plan_row(mstt_pkg::OP_CHECK, TIME_MAX, '0, 1'b0, '0, 1, 0, none);
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, 4'd15, 1, 0, none);
      plan_row(mstt_pkg::OP_CANCEL, '0, '0, 1'b0, 4'd1, 1, 0, none);
      plan_row(mstt_pkg::OP_CHECK, TIME_MAX, '0, 1'b0, '0, 1, 1,
               make_alarm_rsp('0, 1'b0, mstt_pkg::ST_OK, 1'b1));

      foreach (directed_plan[i]) begin
         repeat (directed_plan[i].repeats)
            send_alarm_req(directed_plan[i].item, directed_plan[i].typed,
                           directed_plan[i].want);
      end

      // Random items in three idling phases; the sender drains the block between them.
      wall_ms = 48'd1000;
      for (int phase = 0; phase < 3; phase++) begin
         req_valid <= 1'b0;
         while (pending_alarms.size() != 0) @(posedge clock);
         if (phase == 1) begin
            req_idle_pct <= 80;
            rsp_idle_pct <= 19;
         end else if (phase == 2) begin
            req_idle_pct <= 0;
            rsp_idle_pct <= 0;
            hold_req <= hold_req + 1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            wall_ms = wall_ms + 48'($urandom_range(60));
            it = random_alarm_req(wall_ms);
            send_alarm_req(it, 1'b0, none);
         end
      end
      req_valid <= 1'b0;

      while (pending_alarms.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/mstt_pkg.sv
sv/mstt_ram.sv
sv/mstt_ctrl.sv
sv/mstt_dp.sv
sv/multi_slot_alarm_timer_table.sv
tb/multi_slot_alarm_timer_table_tb.sv
